[rtl/mbe_pkg.sv]
package mbe_pkg;

    // Field and register widths.
    localparam int PIX_W = 8;
    localparam int LW_W  = 11;
    localparam int FH_W  = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Default for the widest line the block is built for.
    localparam int MAX_WIDTH_DEF = 1024;

    // Reset values of the configuration registers.
    localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Item kinds carried in s_tuser.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Full-scale sample; only a window of these erodes.
    localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;

    // Control shared by all line cells.
    typedef struct packed {
        logic adv;     // a beat was accepted, every cell moves one step
        logic clr;     // restart the write pointer
        logic bypass;  // one-pixel lines: the cell is a single register
    } cell_ctrl_t;

endpackage

[rtl/mbe_line_cell.sv]
module mbe_line_cell #(
    parameter int MAX_WIDTH = mbe_pkg::MAX_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mbe_pkg::cell_ctrl_t                ctrl,
    input  logic [$clog2(MAX_WIDTH-1)-1:0]     wrap_at,
    input  logic [mbe_pkg::PIX_W-1:0]          din,
    output logic [mbe_pkg::PIX_W-1:0]          dout
);
    import mbe_pkg::*;

    localparam int DEPTH = MAX_WIDTH - 1;
    localparam int AW    = $clog2(DEPTH);

    // The memory holds one line minus one sample; the output register
    // supplies the last step, so the cell delays by exactly one line.
    logic [PIX_W-1:0] line_mem [DEPTH];
    logic [AW-1:0]    ptr_reg;
    logic [AW-1:0]    ptr_next;
    logic [PIX_W-1:0] out_reg;

    always_comb begin
        ptr_next = ptr_reg;
        if (ctrl.clr) begin
            ptr_next = '0;
        end else if (ctrl.adv && !ctrl.bypass) begin
            ptr_next = (ptr_reg == wrap_at) ? '0 : ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else begin
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            out_reg <= ctrl.bypass ? din : line_mem[ptr_reg];
            if (!ctrl.bypass) begin
                line_mem[ptr_reg] <= din;
            end
        end
    end

    assign dout = out_reg;

endmodule

[rtl/morph_boundary_extract_cross5.sv]
// Boundary extraction of an 8-bit grayscale raster stream by erosion with a
// 5x5 plus-shaped element. A pixel erodes only if it and its eight cross
// neighbors (two up, two down, two left, two right) are all 255, pixels
// outside the image counting as 0; the output is 0 for an eroded pixel and
// the original value otherwise. One beat is taken per clock; the input is
// held back only while a finished result waits in the output register and
// the receiver is not ready for it.
// The result for a pixel leaves after the beat that lies 2*line_width+2
// positions later in raster order, so the first 2*line_width+2 beats of a
// frame give no result and a frame must be followed by 2*line_width+2 flush
// beats (s_tuser = 1, read as zero pixels) to push its last results out;
// m_tlast marks the last pixel of the frame. The window is built from a row
// of four identical line cells, each a one-line delay in its own memory of
// MAX_WIDTH-1 samples, plus a few registers, so all work stays at one beat
// per cycle. A line width of 0 counts as 1 and one above MAX_WIDTH counts as
// MAX_WIDTH; a frame height of 0 counts as 1. Writing a register restarts
// the frame. No clearing pass is needed after reset: stale line contents
// only ever stand for pixels outside the image, which read as 0.
module morph_boundary_extract_cross5 #(
    parameter int MAX_WIDTH = mbe_pkg::MAX_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mbe_pkg::PIX_W-1:0]         s_tdata,   // [7:0] pixel
    input  logic                              s_tuser,   // [0] op
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mbe_pkg::PIX_W-1:0]         m_tdata,   // [7:0] boundary_pixel
    output logic                              m_tlast    // frame_end
);
    import mbe_pkg::*;

    // Widths that follow from the largest line.
    localparam int WW = $clog2(MAX_WIDTH + 1);       // effective width
    localparam int EW = WW + 1;                      // width plus headroom
    localparam int AW = $clog2(MAX_WIDTH - 1);       // line cell address
    localparam int CW = $clog2(MAX_WIDTH);           // column counter
    localparam int PW = $clog2(2 * MAX_WIDTH + 3);   // priming counter
    localparam int RW = FH_W + 1;                    // row compare width

    // Configuration registers.
    logic [LW_W-1:0] line_width_reg;
    logic [FH_W-1:0] frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LINE_WIDTH:   line_width_reg   <= cfg_wdata[LW_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame geometry after clamping.
    logic [WW-1:0]   w_eff;
    logic [FH_W-1:0] h_eff;

    always_comb begin
        if (line_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(line_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(line_width_reg);
        end
    end

    assign h_eff = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;

    // Handshake. The output register is the only thing that can hold back
    // the input: a new beat enters whenever the held result leaves or the
    // register is empty.
    logic             m_tvalid_reg;
    logic [PIX_W-1:0] m_data_reg;
    logic             m_last_reg;
    logic             s_acc;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    // A flush beat enters the window as a zero pixel.
    logic [PIX_W-1:0] pix_in;
    assign pix_in = (s_tuser == OP_FLUSH) ? '0 : s_tdata;

    // Line cells. Cell 0 and 1 bring the centre row up to the window;
    // cells 2 and 3 take the centre pixel and produce the rows above it.
    cell_ctrl_t       cell_ctrl;
    logic [AW-1:0]    wrap_at;
    logic [PIX_W-1:0] cell_din  [4];
    logic [PIX_W-1:0] cell_dout [4];

    assign wrap_at          = (w_eff >= WW'(2)) ? AW'(w_eff - WW'(2)) : '0;
    assign cell_ctrl.adv    = s_acc;
    assign cell_ctrl.clr    = cfg_we;
    assign cell_ctrl.bypass = (w_eff == WW'(1));

    // Centre row window: position 0 is the newest, position 2 the centre.
    logic [PIX_W-1:0] win_reg [1:4];
    logic [PIX_W-1:0] win0;
    assign win0 = cell_dout[1];

    assign cell_din[0] = pix_in;
    assign cell_din[1] = cell_dout[0];
    assign cell_din[2] = win_reg[2];
    assign cell_din[3] = cell_dout[2];

    for (genvar i = 0; i < 4; i++) begin : g_cell
        mbe_line_cell #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl),
            .wrap_at (wrap_at),
            .din     (cell_din[i]),
            .dout    (cell_dout[i])
        );
    end

    // Short delays that line up the two rows below the centre: two beats
    // behind the input, and two beats behind the first line cell.
    logic [PIX_W-1:0] below2_d1_reg, below2_reg;
    logic [PIX_W-1:0] below1_d1_reg, below1_reg;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            below2_d1_reg <= pix_in;
            below2_reg    <= below2_d1_reg;
            below1_d1_reg <= cell_dout[0];
            below1_reg    <= below1_d1_reg;
            win_reg[1]    <= win0;
            win_reg[2]    <= win_reg[1];
            win_reg[3]    <= win_reg[2];
            win_reg[4]    <= win_reg[3];
        end
    end

    // Position of the centre that the next beat completes.
    logic [PW-1:0]   prime_reg, prime_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [FH_W-1:0] row_reg, row_next;
    logic [PW-1:0]   prime_target;
    logic            primed;

    assign prime_target = PW'({w_eff, 1'b0}) + PW'(2);
    assign primed       = (prime_reg >= prime_target);

    // Bounds of the cross around the centre.
    logic [EW-1:0] col_x, w_x;
    logic [RW-1:0] row_x, h_x;
    logic          c_ge1, c_ge2, c_p1, c_p2, last_col;
    logic          r_ge1, r_ge2, r_p1, r_p2, last_row;

    assign col_x    = EW'(col_reg);
    assign w_x      = EW'(w_eff);
    assign row_x    = RW'(row_reg);
    assign h_x      = RW'(h_eff);
    assign c_ge1    = (col_reg != '0);
    assign c_ge2    = (col_reg >= CW'(2));
    assign c_p1     = ((col_x + EW'(1)) < w_x);
    assign c_p2     = ((col_x + EW'(2)) < w_x);
    assign last_col = ((col_x + EW'(1)) >= w_x);
    assign r_ge1    = (row_reg != '0);
    assign r_ge2    = (row_reg >= FH_W'(2));
    assign r_p1     = ((row_x + RW'(1)) < h_x);
    assign r_p2     = ((row_x + RW'(2)) < h_x);
    assign last_row = ((row_x + RW'(1)) >= h_x);

    // The centre erodes only when every arm of the cross lies inside the
    // image and reads full scale; any arm outside the image reads as 0.
    logic eroded;
    logic frame_last;

    assign eroded = (win_reg[2] == PIX_FULL)
                 && c_ge1 && (win_reg[3] == PIX_FULL)
                 && c_ge2 && (win_reg[4] == PIX_FULL)
                 && c_p1  && (win_reg[1] == PIX_FULL)
                 && c_p2  && (win0 == PIX_FULL)
                 && r_ge1 && (cell_dout[2] == PIX_FULL)
                 && r_ge2 && (cell_dout[3] == PIX_FULL)
                 && r_p1  && (below1_reg == PIX_FULL)
                 && r_p2  && (below2_reg == PIX_FULL);

    assign frame_last = last_row && last_col;

    always_comb begin
        prime_next = prime_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (cfg_we) begin
            prime_next = '0;
            col_next   = '0;
            row_next   = '0;
        end else if (s_acc) begin
            if (!primed) begin
                prime_next = prime_reg + PW'(1);
            end else if (frame_last) begin
                prime_next = '0;
                col_next   = '0;
                row_next   = '0;
            end else if (last_col) begin
                col_next = '0;
                row_next = row_reg + FH_W'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            prime_reg <= prime_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_acc && primed) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && primed) begin
            m_data_reg <= eroded ? '0 : win_reg[2];
            m_last_reg <= frame_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbe_pkg::*;

    // The history store covers four full lines plus the centre-row window.
    localparam int HIST_DEPTH = 4 * MAX_WIDTH_DEF + 8;
    // Cycles to wait after the last expected result before touching a register.
    localparam int SETTLE_CYCLES = 16;
    // Cycles allowed after the final result before the verdict.
    localparam int DRAIN_CYCLES = 20;
    // Cycles with no beat on either side before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    localparam int RANDOM_BEATS = 1050;
    // Line width of the closing frame of zero height.
    localparam int WIDE_LINE = 200;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } boundary_beat_t;

    // Predicts the boundary image from the accepted input beats and checks
    // every result beat against the oldest prediction.
    class boundary_scoreboard;
        logic [LW_W-1:0]  line_width;
        logic [FH_W-1:0]  frame_height;
        logic [PIX_W-1:0] history [HIST_DEPTH];
        int               head;
        int               beats_in_frame;
        int               col;
        int               row;
        boundary_beat_t   due_q [$];
        int               errors;

        function new();
            errors = 0;
            reset_state();
        endfunction

        function void reset_state();
            line_width   = LINE_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            foreach (history[i]) history[i] = '0;
            head = 0;
            restart();
        endfunction

        function void restart();
            beats_in_frame = 0;
            col = 0;
            row = 0;
        endfunction

        function int eff_width();
            if (line_width == 0) return 1;
            if (line_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return line_width;
        endfunction

        function int eff_height();
            return (frame_height == 0) ? 1 : frame_height;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_LINE_WIDTH) begin
                line_width = val[LW_W-1:0];
            end else if (idx == CFG_FRAME_HEIGHT) begin
                frame_height = val[FH_W-1:0];
            end
            restart();
        endfunction

        // Sample at row offset dr and column offset dc from the current centre.
        function int tap(int dr, int dc, int w, int h);
            int r;
            int c;
            int back;
            r = row + dr;
            c = col + dc;
            if (r < 0 || c < 0 || r >= h || c >= w) return 0;
            back = 2 * w + 2 - dr * w - dc;
            return history[(head + HIST_DEPTH - (back % HIST_DEPTH)) % HIST_DEPTH];
        endfunction

        function void note_beat(logic op, logic [PIX_W-1:0] pix);
            int             w;
            int             h;
            bit             eroded;
            boundary_beat_t exp_beat;
            w = eff_width();
            h = eff_height();
            head = (head + 1) % HIST_DEPTH;
            history[head] = (op == OP_FLUSH) ? '0 : pix;
            if (beats_in_frame < 2 * w + 2) begin
                beats_in_frame++;
                return;
            end
            beats_in_frame++;
            eroded = 1'b1;
            for (int k = -2; k <= 2; k++) begin
                if (tap(k, 0, w, h) != PIX_FULL) eroded = 1'b0;
                if (tap(0, k, w, h) != PIX_FULL) eroded = 1'b0;
            end
            exp_beat.pixel     = eroded ? '0 : PIX_W'(tap(0, 0, w, h));
            exp_beat.frame_end = (row + 1 >= h) && (col + 1 >= w);
            due_q.push_back(exp_beat);
            if (exp_beat.frame_end) begin
                restart();
            end else if (col + 1 >= w) begin
                col = 0;
                row++;
            end else begin
                col++;
            end
        endfunction

        function void check_result(logic [PIX_W-1:0] pix, logic last);
            boundary_beat_t exp_beat;
            if (due_q.size() == 0) begin
                $display("%0t: result pixel %0d last %0d arrived with none expected",
                         $time, pix, last);
                errors++;
                return;
            end
            exp_beat = due_q.pop_front();
            if (pix !== exp_beat.pixel) begin
                $display("%0t: boundary pixel expected %0d actual %0d",
                         $time, exp_beat.pixel, pix);
                errors++;
            end
            if (last !== exp_beat.frame_end) begin
                $display("%0t: frame end expected %0d actual %0d",
                         $time, exp_beat.frame_end, last);
                errors++;
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tlast;

    boundary_scoreboard sb = new();

    // When set, neither side inserts gaps, so the block runs at full rate.
    bit full_rate;
    int beats_sent;
    int idle_cycles;

    morph_boundary_extract_cross5 #(
        .MAX_WIDTH(MAX_WIDTH_DEF)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Most gaps are short, a few are long enough to drain or fill the
    // block's internal pipeline.
    function automatic int pick_gap();
        int r;
        if (full_rate) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // The receiver alternates between runs of ready and stalls of random
    // length, so back-pressure lands on every phase of a frame.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(1, 8) - 1) @(negedge aclk);
        end
    end

    // Every accepted result beat is checked at the rising edge on which it
    // is taken, before the block updates its outputs.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast);
        end
    end

    // A run that stops moving beats for too long is declared hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // Presents one input beat after a random gap and holds it until the
    // block takes it. The task starts and ends on a falling edge.
    task automatic push_beat(input logic op, input logic [PIX_W-1:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = pix;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(op, pix);
        beats_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Waits until every predicted result has come out, then gives the block
    // time to finish any beat that produces no result.
    task automatic settle();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Registers are only written while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Sends one frame at the current geometry. A whole frame is followed by
    // the 2*width+2 padding beats that push its last results out; a cut-off
    // frame stops somewhere inside the image. Pixels lean toward full scale
    // so that erosion actually happens, and now and then a flush beat lands
    // inside the image or a pixel beat lands in the padding.
    task automatic send_frame(input bit whole);
        int w;
        int h;
        int count;
        int density;
        w = sb.eff_width();
        h = sb.eff_height();
        density = $urandom_range(60, 98);
        count = whole ? w * h : $urandom_range(1, w * h);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 39) == 0) begin
                push_beat(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 99) < density) begin
                push_beat(OP_PIXEL, PIX_FULL);
            end else begin
                push_beat(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
            end
        end
        if (whole) begin
            for (int i = 0; i < 2 * w + 2; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    push_beat(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
                end else begin
                    push_beat(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // Random beats with no frame structure at all.
    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++) begin
            push_beat(logic'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int target;
        int lw;
        int fh;
        int pick;

        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_LINE_WIDTH;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_PIXEL;
        full_rate  = 1'b0;
        beats_sent = 0;
        idle_cycles = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // A 5x5 frame is the smallest in which a centre can erode: all of it
        // is full scale except a zero corner, so only the middle pixel gives
        // 0. Half of the padding is pixel beats that must act as flushes.
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(5));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(5));
        for (int i = 0; i < 25; i++) begin
            push_beat(OP_PIXEL, (i == 0) ? '0 : PIX_FULL);
        end
        for (int i = 0; i < 12; i++) begin
            push_beat((i < 6) ? OP_FLUSH : OP_PIXEL, PIX_FULL);
        end
        settle();

        // A one-pixel frame whose only pixel is a flush beat carrying data
        // that must be ignored.
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(1));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(1));
        push_beat(OP_FLUSH, PIX_FULL);
        push_beat(OP_PIXEL, 8'h5A);
        push_beat(OP_FLUSH, 8'hA5);
        push_beat(OP_PIXEL, PIX_FULL);
        push_beat(OP_FLUSH, '0);
        settle();

        // All-ones register values: the width clamps to the widest line, so
        // these beats stay in the priming stretch and give nothing.
        write_reg(CFG_FRAME_HEIGHT, '1);
        write_reg(CFG_LINE_WIDTH, '1);
        send_noise(30);
        settle();

        // One-pixel lines in the tallest frame the register allows; the run
        // is cut short by the next register write.
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(1));
        full_rate = 1'b1;
        send_noise(40);
        full_rate = 1'b0;
        settle();

        // Random phases: a fresh geometry, mostly small so that many frames
        // complete, with zero width or height now and then. Each phase
        // carries a few frames, whole or cut off, or plain noise.
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            pick = $urandom_range(0, 9);
            lw = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            pick = $urandom_range(0, 9);
            fh = (pick == 0) ? 0 : (lw <= 8 && pick == 1) ? $urandom_range(7, 16)
                                                          : $urandom_range(1, 6);
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(lw));
                write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(fh));
            end else begin
                write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(fh));
                write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(lw));
            end
            full_rate = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    send_noise($urandom_range(1, 30));
                end else begin
                    send_frame(pick != 1);
                end
            end
            full_rate = 1'b0;
            settle();
        end

        // A wide line in a frame of zero height, which counts as one row.
        write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(WIDE_LINE));
        write_reg(CFG_FRAME_HEIGHT, '0);
        send_frame(1'b1);
        settle();

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/mbe_pkg.sv
rtl/mbe_line_cell.sv
rtl/morph_boundary_extract_cross5.sv
tb/tb.sv
